// ===== hdl/rdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rdq_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 2;

  localparam logic [ActionW-1:0] ACT_CLEAR   = 3'd0;
  localparam logic [ActionW-1:0] ACT_APPEND  = 3'd1;
  localparam logic [ActionW-1:0] ACT_REVERSE = 3'd2;
  localparam logic [ActionW-1:0] ACT_DROP    = 3'd3;
  localparam logic [ActionW-1:0] ACT_REPORT  = 3'd4;

  localparam logic [StatusW-1:0] STAT_ELEMENT = 2'd0;
  localparam logic [StatusW-1:0] STAT_EMPTY   = 2'd1;
  localparam logic [StatusW-1:0] STAT_ERROR   = 2'd2;

  typedef enum logic [2:0] {
    OP_CLEAR,
    OP_APPEND,
    OP_REVERSE,
    OP_DROP,
    OP_REPORT
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic signed [ValueW-1:0] value;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/rdq_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rdq_in_if;
  logic                               valid;
  logic                               ready;
  logic [rdq_pkg::ActionW-1:0]        action;
  logic signed [rdq_pkg::ValueW-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink (input valid, input action, input value, output ready);
endinterface
`default_nettype wire

// ===== hdl/rdq_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface rdq_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rdq_pkg::ValueW-1:0]  element;
  logic [rdq_pkg::StatusW-1:0]        status;
  logic                               last;

  modport source (output valid, output element, output status, output last, input ready);
  modport sink (input valid, input element, input status, input last, output ready);
endinterface
`default_nettype wire

// ===== hdl/rdq_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rdq_front (
  rdq_in_if.sink        req,
  input  wire logic     q_full,
  output logic          q_push,
  output rdq_pkg::cmd_t q_cmd
);

  logic legal;

  always_comb begin
    legal        = 1'b1;
    q_cmd.value  = req.value;
    q_cmd.op     = rdq_pkg::OP_CLEAR;
    case (req.action)
      rdq_pkg::ACT_CLEAR:   q_cmd.op = rdq_pkg::OP_CLEAR;
      rdq_pkg::ACT_APPEND:  q_cmd.op = rdq_pkg::OP_APPEND;
      rdq_pkg::ACT_REVERSE: q_cmd.op = rdq_pkg::OP_REVERSE;
      rdq_pkg::ACT_DROP:    q_cmd.op = rdq_pkg::OP_DROP;
      rdq_pkg::ACT_REPORT:  q_cmd.op = rdq_pkg::OP_REPORT;
      default:              legal = 1'b0;  // unused codes are swallowed
    endcase
  end

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full && legal;

endmodule
`default_nettype wire

// ===== hdl/rdq_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rdq_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rdq_pkg::cmd_t  push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output rdq_pkg::cmd_t       head_cmd
);

  rdq_pkg::cmd_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign full       = (fill == 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= 2'd2)
    else $error("queue fill out of range");
  assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

endmodule
`default_nettype wire

// ===== hdl/rdq_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rdq_back #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire rdq_pkg::cmd_t  q_cmd,
  output logic                q_pop,
  rdq_out_if.source           rsp
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] p);
    pos_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] pos_dec(input logic [PW-1:0] p);
    pos_dec = (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  logic signed [rdq_pkg::ValueW-1:0] mem [DEPTH];
  logic signed [rdq_pkg::ValueW-1:0] rd_data;

  state_t        state;
  logic [PW-1:0] front_pos;
  logic [PW-1:0] back_pos;
  logic [CW-1:0] live_count;
  logic          reversed;
  logic          error_flag;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] remaining;

  logic                       pend_valid;
  logic                       pend_from_mem;
  logic [rdq_pkg::StatusW-1:0] pend_status;
  logic                       pend_last;

  logic                       out_valid;
  logic signed [rdq_pkg::ValueW-1:0] out_element;
  logic [rdq_pkg::StatusW-1:0] out_status;
  logic                       out_last;

  logic          out_move;
  logic          stage_free;
  logic          is_report;
  logic          start_single;
  logic          start_stream;
  logic          rd_en;
  logic [PW-1:0] rd_addr;
  logic          rd_last;
  logic          wr_en;
  logic [PW-1:0] wr_addr;
  logic [PW-1:0] stream_start;

  assign out_move   = !out_valid || rsp.ready;
  assign stage_free = !pend_valid || out_move;
  assign is_report  = (q_cmd.op == rdq_pkg::OP_REPORT);
  assign q_pop      = q_valid && (state == ST_IDLE) && (!is_report || stage_free);

  assign start_single = q_pop && is_report && (error_flag || live_count == '0);
  assign start_stream = q_pop && is_report && !error_flag && (live_count != '0);
  assign stream_start = reversed ? pos_dec(back_pos) : front_pos;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = rd_ptr;
    rd_last = 1'b0;
    if (start_stream) begin
      rd_en   = 1'b1;
      rd_addr = stream_start;
      rd_last = (live_count == CW'(1));
    end else if (state == ST_STREAM && stage_free) begin
      rd_en   = 1'b1;
      rd_addr = rd_ptr;
      rd_last = (remaining == CW'(1));
    end
  end

  assign wr_en   = q_pop && (q_cmd.op == rdq_pkg::OP_APPEND) && !error_flag
                   && (live_count != CW'(DEPTH));
  assign wr_addr = reversed ? pos_dec(front_pos) : back_pos;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= q_cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      front_pos  <= '0;
      back_pos   <= '0;
      live_count <= '0;
      reversed   <= 1'b0;
      error_flag <= 1'b0;
      rd_ptr     <= '0;
      remaining  <= '0;
    end else begin
      if (q_pop) begin
        case (q_cmd.op)
          rdq_pkg::OP_CLEAR: begin
            front_pos  <= '0;
            back_pos   <= '0;
            live_count <= '0;
            reversed   <= 1'b0;
            error_flag <= 1'b0;
          end
          rdq_pkg::OP_APPEND: begin
            if (!error_flag) begin
              if (live_count == CW'(DEPTH)) begin
                error_flag <= 1'b1;
              end else begin
                if (reversed) begin
                  front_pos <= pos_dec(front_pos);
                end else begin
                  back_pos <= pos_inc(back_pos);
                end
                live_count <= live_count + CW'(1);
              end
            end
          end
          rdq_pkg::OP_REVERSE: begin
            if (!error_flag) begin
              reversed <= !reversed;
            end
          end
          rdq_pkg::OP_DROP: begin
            if (!error_flag) begin
              if (live_count == '0) begin
                error_flag <= 1'b1;
              end else begin
                if (reversed) begin
                  back_pos <= pos_dec(back_pos);
                end else begin
                  front_pos <= pos_inc(front_pos);
                end
                live_count <= live_count - CW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end

      if (rd_en) begin
        rd_ptr    <= reversed ? pos_dec(rd_addr) : pos_inc(rd_addr);
        remaining <= start_stream ? live_count - CW'(1) : remaining - CW'(1);
      end

      case (state)
        ST_IDLE: begin
          if (start_stream && live_count != CW'(1)) begin
            state <= ST_STREAM;
          end
        end
        ST_STREAM: begin
          if (rd_en && rd_last) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result staging: read data sits beside pend_*, then the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (rd_en || start_single) begin
        pend_valid <= 1'b1;
      end else if (out_move) begin
        pend_valid <= 1'b0;
      end
      if (out_move) begin
        out_valid <= pend_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      pend_from_mem <= 1'b1;
      pend_status   <= rdq_pkg::STAT_ELEMENT;
      pend_last     <= rd_last;
    end else if (start_single) begin
      pend_from_mem <= 1'b0;
      pend_status   <= error_flag ? rdq_pkg::STAT_ERROR : rdq_pkg::STAT_EMPTY;
      pend_last     <= 1'b1;
    end
    if (out_move && pend_valid) begin
      out_element <= pend_from_mem ? rd_data : '0;
      out_status  <= pend_status;
      out_last    <= pend_last;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.element = out_element;
  assign rsp.status  = out_status;
  assign rsp.last    = out_last;

  assert property (@(posedge clk) disable iff (rst) live_count <= CW'(DEPTH))
    else $error("live count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
                   (live_count == '0) |-> (front_pos == back_pos))
    else $error("empty list with split ends");
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_STREAM) |-> (remaining != '0))
    else $error("streaming with nothing left");
  assert property (@(posedge clk) disable iff (rst)
                   (rd_en || start_single) |-> stage_free)
    else $error("result staged over an unsent one");
  assert property (@(posedge clk) disable iff (rst) rd_en |=> pend_valid)
    else $error("read data not staged");

endmodule
`default_nettype wire

// ===== hdl/reversible_deque_drop_front.sv =====
// Reversible list store with drop-front and report.
// Channels: req (sink) carries action and value; rsp (source) carries
// element, status and last. An item moves when valid and ready are both high.
// req is taken into a two-entry command queue; unused action codes are
// accepted and discarded. A back end pops one command per cycle while no
// report runs and, for a report, while the result stage is free; clear,
// append, reverse and drop take effect as they are popped. A report yields
// one result per cycle for each live element while rsp is not stalled, or
// a single empty or error result. During a run the back end takes no
// further command. Element storage is a single-port RAM read one slot per
// cycle while rsp is not stalled, into a registered read port, with the
// result flags staged beside it, then the output register; a stall on rsp
// halts the run without loss, and req keeps being accepted until the
// command queue fills.
// Reset (rst, synchronous) empties the list in forward order and clears the
// error; storage contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module reversible_deque_drop_front #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  rdq_in_if.sink     req,
  rdq_out_if.source  rsp
);

  logic          q_full;
  logic          q_push;
  rdq_pkg::cmd_t q_in;
  logic          q_pop;
  logic          q_valid;
  rdq_pkg::cmd_t q_head;

  rdq_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_cmd  (q_in)
  );

  rdq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head)
  );

  rdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (q_head),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rdq_pkg::*;

  localparam int Depth = 64;
  localparam int HoldCycles = 300;
  localparam logic [ActionW-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ActionW-1:0] ACT_UNUSED_HI = 3'd7;

  typedef struct {
    logic signed [ValueW-1:0] element;
    logic [StatusW-1:0]       status;
    logic                     last;
  } result_t;

  typedef struct {
    logic [ActionW-1:0]       act;
    logic signed [ValueW-1:0] val;
    bit                       typed;
    logic signed [ValueW-1:0] t_elem;
    logic [StatusW-1:0]       t_stat;
  } row_t;

  logic clk;
  logic rst;

  rdq_in_if  req_ch();
  rdq_out_if rsp_ch();

  reversible_deque_drop_front #(.DEPTH(Depth)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // shadow of the list
  logic signed [ValueW-1:0] slots [Depth];
  logic [5:0] head;
  logic [5:0] tail;
  logic [6:0] count;
  bit         flipped;
  bit         fault;

  result_t step_results [$];
  result_t pending_results [$];
  result_t oldest;

  int send_idle_pct;
  int recv_idle_pct;
  int stall_asks;
  int stall_seen;
  int hold_left;
  int mismatches;
  int items_sent;
  int results_checked;
  int reports_seen;
  int faults_hit;

  row_t directed_rows [25];

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic apply_action(input logic [ActionW-1:0] act, input logic signed [ValueW-1:0] val);
    result_t r;
    int k;
    step_results.delete();
    case (act)
      ACT_CLEAR: begin
        head = '0;
        tail = '0;
        count = '0;
        flipped = 1'b0;
        fault = 1'b0;
      end
      ACT_APPEND: begin
        if (!fault) begin
          if (count >= Depth) begin
            fault = 1'b1;
            faults_hit++;
          end else begin
            if (!flipped) begin
              slots[tail] = val;
              tail = tail + 6'd1;
            end else begin
              head = head - 6'd1;
              slots[head] = val;
            end
            count = count + 7'd1;
          end
        end
      end
      ACT_REVERSE: begin
        if (!fault) flipped = !flipped;
      end
      ACT_DROP: begin
        if (!fault) begin
          if (count == 0) begin
            fault = 1'b1;
            faults_hit++;
          end else begin
            if (!flipped) head = head + 6'd1;
            else tail = tail - 6'd1;
            count = count - 7'd1;
          end
        end
      end
      ACT_REPORT: begin
        reports_seen++;
        if (fault || count == 0) begin
          r.element = '0;
          r.status = fault ? STAT_ERROR : STAT_EMPTY;
          r.last = 1'b1;
          step_results.push_back(r);
        end else begin
          for (k = 0; k < int'(count); k++) begin
            r.element = slots[6'(int'(head) + (flipped ? int'(count) - 1 - k : k))];
            r.status = STAT_ELEMENT;
            r.last = (k + 1 == int'(count));
            step_results.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(input logic [ActionW-1:0] act, input logic signed [ValueW-1:0] val,
                           input bit typed = 1'b0,
                           input logic signed [ValueW-1:0] typed_elem = '0,
                           input logic [StatusW-1:0] typed_stat = STAT_ELEMENT);
    result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.action = act;
    req_ch.value = val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_action(act, val);
    if (typed) begin
      r.element = typed_elem;
      r.status = typed_stat;
      r.last = 1'b1;
      pending_results.push_back(r);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    req_ch.valid = 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic run_random(input int n);
    int r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 8) send_item(ACT_CLEAR, $urandom);
      else if (r < 50) send_item(ACT_APPEND, $urandom);
      else if (r < 62) send_item(ACT_REVERSE, $urandom);
      else if (r < 78) send_item(ACT_DROP, $urandom);
      else if (r < 94) send_item(ACT_REPORT, $urandom);
      else send_item(ActionW'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)), $urandom);
    end
  endtask

  always @(negedge clk) begin
    if (stall_asks != stall_seen) begin
      stall_seen = stall_asks;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result element %0d status %0d last %0d",
                                rsp_ch.element, rsp_ch.status, rsp_ch.last));
      end else begin
        oldest = pending_results.pop_front();
        if (rsp_ch.element !== oldest.element)
          flag_mismatch($sformatf("element got %0d want %0d", rsp_ch.element, oldest.element));
        if (rsp_ch.status !== oldest.status)
          flag_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, oldest.status));
        if (rsp_ch.last !== oldest.last)
          flag_mismatch($sformatf("last got %0d want %0d", rsp_ch.last, oldest.last));
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.action = ACT_CLEAR;
    req_ch.value = '0;
    rsp_ch.ready = 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 48;
    stall_asks = 0;
    stall_seen = 0;
    hold_left = 0;
    mismatches = 0;
    items_sent = 0;
    results_checked = 0;
    reports_seen = 0;
    faults_hit = 0;
    head = '0;
    tail = '0;
    count = '0;
    flipped = 1'b0;
    fault = 1'b0;

    directed_rows = '{
      '{ACT_REPORT,  32'sd0,           1'b1, 32'sd0,           STAT_EMPTY},
      '{ACT_DROP,    32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b1, 32'sd0,           STAT_ERROR},
      '{ACT_APPEND,  32'sd5,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REVERSE, 32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_DROP,    32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b1, 32'sd0,           STAT_ERROR},
      '{ACT_CLEAR,   -32'sd1,          1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b1, 32'sd0,           STAT_EMPTY},
      '{ACT_APPEND,  32'sh7fffffff,    1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b1, 32'sh7fffffff,    STAT_ELEMENT},
      '{ACT_DROP,    32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_APPEND,  32'sh80000000,    1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b1, 32'sh80000000,    STAT_ELEMENT},
      '{ACT_APPEND,  -32'sd1,          1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_APPEND,  32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REVERSE, -32'sd1,          1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_APPEND,  32'sh5a5a5a5a,    1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_DROP,    32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_UNUSED_LO, -32'sd1,        1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_UNUSED_HI, 32'sd0,         1'b0, 32'sd0,           STAT_ELEMENT},
      '{ACT_REPORT,  32'sd0,           1'b0, 32'sd0,           STAT_ELEMENT}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].val, directed_rows[i].typed,
                directed_rows[i].t_elem, directed_rows[i].t_stat);

    // fill across the ring wrap, then hold the output while input backs up
    send_item(ACT_CLEAR, $urandom);
    send_item(ACT_REVERSE, $urandom);
    repeat (20) send_item(ACT_APPEND, $urandom);
    send_item(ACT_REVERSE, $urandom);
    repeat (Depth - 20) send_item(ACT_APPEND, $urandom);
    stall_asks++;
    send_item(ACT_REPORT, $urandom);
    send_item(ACT_APPEND, $urandom);
    send_item(ACT_REPORT, $urandom);
    send_item(ACT_CLEAR, $urandom);
    run_random(60);
    drain();

    send_idle_pct = 48;
    recv_idle_pct = 16;
    run_random(90);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(90);

    drain();
    repeat (20) @(posedge clk);

    $display("Covered %0d items over three idle mixes, with a full store, overflow and a %0d-cycle output hold",
             items_sent, HoldCycles);
    $display("Checked %0d results from %0d reports; %0d error conditions raised",
             results_checked, reports_seen, faults_hit);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rdq_pkg.sv
hdl/rdq_in_if.sv
hdl/rdq_out_if.sv
hdl/rdq_front.sv
hdl/rdq_queue.sv
hdl/rdq_back.sv
hdl/reversible_deque_drop_front.sv
bench/tb_top.sv
